FILE: hdl/life_like_generation_step_defines.svh
`ifndef LIFE_LIKE_GENERATION_STEP_DEFINES_SVH
`define LIFE_LIKE_GENERATION_STEP_DEFINES_SVH

// Implication checked in the same cycle.
`define LLGS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("llgs check failed");

// Implication checked in the next cycle.
`define LLGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("llgs check failed");

`endif

FILE: hdl/llgs_pkg.sv
package llgs_pkg;

  localparam int GRID_WIDTH = 64;
  localparam int ROW_W      = 64;
  localparam int MASK_W     = 9;
  localparam int NCNT_W     = 4;

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_BIRTH   = 1'b0;
  localparam logic REG_SURVIVE = 1'b1;

  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

  localparam int OUTQ_DEPTH = 3;
  localparam int CNT_W      = $clog2(OUTQ_DEPTH + 1);
  localparam int PUSH_W     = 2;

  typedef struct packed {
    logic              load;
    logic              mid_valid;
    logic              last;
    logic [MASK_W-1:0] birth;
    logic [MASK_W-1:0] survive;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             fend;
  } out_word_t;

endpackage

FILE: hdl/life_like_generation_step.sv
// One generation of a Life-like automaton, streamed one grid row per input word.
// Each accepted row yields the next generation of the row above it, so output
// runs one row behind; a row flagged last_row also yields its own next row,
// tagged frame_end, and the block then starts a fresh frame. Cells outside the
// grid count as dead. A row is accepted every cycle while in_stall_o is low: a
// chain of column cells holds the two previous rows and all neighbor counts are
// evaluated in parallel. Words wait in a three-entry output queue; in_stall_o
// rises while it holds two or more words, as it does after the last row of a
// frame longer than one row. Registers: birth_mask at byte 0, survive_mask at
// byte 4 (bit n = neighbor count n), reset B3/S23.
`include "life_like_generation_step_defines.svh"

module life_like_generation_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [llgs_pkg::ROW_W-1:0]    row_cells_i,
  input  logic                          last_row_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [llgs_pkg::ROW_W-1:0]    next_row_o,
  output logic                          frame_end_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llgs_pkg::APB_AW-1:0]   paddr,
  input  logic [llgs_pkg::APB_DW-1:0]   pwdata,
  output logic [llgs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import llgs_pkg::*;

  logic [MASK_W-1:0]     birth_q, survive_q;
  logic                  cfg_wr;
  logic                  mid_valid_q, mid_valid_d;
  logic                  accept;
  cell_ctrl_t            ctrl;

  logic [GRID_WIDTH-1:0] above_bits, mid_bits, cur_bits;
  logic [GRID_WIDTH+1:0] above_pad, mid_pad, cur_pad;
  logic [GRID_WIDTH-1:0] res_a_bits, res_b_bits;

  logic [PUSH_W-1:0]     push_cnt;
  out_word_t             word_a, word_b, push0, push1, head;
  logic [CNT_W-1:0]      q_count;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= BIRTH_RESET;
      survive_q <= SURVIVE_RESET;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_BIRTH:   birth_q   <= pwdata[MASK_W-1:0];
        REG_SURVIVE: survive_q <= pwdata[MASK_W-1:0];
        default:     birth_q   <= birth_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_BIRTH:   prdata = APB_DW'(birth_q);
      REG_SURVIVE: prdata = APB_DW'(survive_q);
      default:     prdata = '0;
    endcase
  end

  // input side
  assign in_stall_o = (q_count >= CNT_W'(2));
  assign accept     = in_valid_i & ~in_stall_o;

  assign mid_valid_d = accept ? ~last_row_i : mid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
    end
  end

  assign ctrl.load      = accept;
  assign ctrl.mid_valid = mid_valid_q;
  assign ctrl.last      = last_row_i;
  assign ctrl.birth     = birth_q;
  assign ctrl.survive   = survive_q;

  // dead cells past both grid edges
  assign cur_bits  = row_cells_i[GRID_WIDTH-1:0];
  assign above_pad = {1'b0, above_bits, 1'b0};
  assign mid_pad   = {1'b0, mid_bits, 1'b0};
  assign cur_pad   = {1'b0, cur_bits, 1'b0};

  for (genvar j = 0; j < GRID_WIDTH; j++) begin : g_col
    llgs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .above_l_i (above_pad[j]),
      .above_r_i (above_pad[j+2]),
      .mid_l_i   (mid_pad[j]),
      .mid_r_i   (mid_pad[j+2]),
      .cur_l_i   (cur_pad[j]),
      .cur_i     (cur_pad[j+1]),
      .cur_r_i   (cur_pad[j+2]),
      .above_o   (above_bits[j]),
      .mid_o     (mid_bits[j]),
      .res_a_o   (res_a_bits[j]),
      .res_b_o   (res_b_bits[j])
    );
  end

  // pending row first, then the last row's own generation
  assign word_a.row  = ROW_W'(res_a_bits);
  assign word_a.fend = 1'b0;
  assign word_b.row  = ROW_W'(res_b_bits);
  assign word_b.fend = 1'b1;

  assign push0    = mid_valid_q ? word_a : word_b;
  assign push1    = word_b;
  assign push_cnt = accept ? (PUSH_W'(mid_valid_q) + PUSH_W'(last_row_i)) : '0;

  llgs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .pop_i      (out_valid_o & ~out_stall_i),
    .head_o     (head),
    .count_o    (q_count)
  );

  assign out_valid_o = (q_count != '0);
  assign next_row_o  = head.row;
  assign frame_end_o = head.fend;

  `LLGS_ASSERT_NOW(a_q_bound, clk_i, rst_ni, 1'b1, q_count <= CNT_W'(OUTQ_DEPTH))
  `LLGS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept && last_row_i, !mid_valid_q)
  `LLGS_ASSERT_NEXT(a_row_pends, clk_i, rst_ni, accept && !last_row_i, mid_valid_q)
  `LLGS_ASSERT_NEXT(a_two_words, clk_i, rst_ni, accept && last_row_i && mid_valid_q,
                    q_count >= CNT_W'(2))

endmodule

FILE: hdl/llgs_cell.sv
module llgs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  llgs_pkg::cell_ctrl_t ctrl_i,
  input  logic                above_l_i,
  input  logic                above_r_i,
  input  logic                mid_l_i,
  input  logic                mid_r_i,
  input  logic                cur_l_i,
  input  logic                cur_i,
  input  logic                cur_r_i,
  output logic                above_o,
  output logic                mid_o,
  output logic                res_a_o,
  output logic                res_b_o
);
  import llgs_pkg::*;

  logic              above_q, above_d;
  logic              mid_q, mid_d;
  logic [NCNT_W-1:0] n_a, n_b;
  logic              up_l, up_c, up_r;

  // neighbors of the pending middle row, with the new row below
  assign n_a = NCNT_W'(above_l_i) + NCNT_W'(above_q) + NCNT_W'(above_r_i)
             + NCNT_W'(mid_l_i) + NCNT_W'(mid_r_i)
             + NCNT_W'(cur_l_i) + NCNT_W'(cur_i) + NCNT_W'(cur_r_i);
  assign res_a_o = mid_q ? ctrl_i.survive[n_a] : ctrl_i.birth[n_a];

  // neighbors of the new row itself, with a dead row below
  assign up_l = ctrl_i.mid_valid & mid_l_i;
  assign up_c = ctrl_i.mid_valid & mid_q;
  assign up_r = ctrl_i.mid_valid & mid_r_i;
  assign n_b = NCNT_W'(up_l) + NCNT_W'(up_c) + NCNT_W'(up_r)
             + NCNT_W'(cur_l_i) + NCNT_W'(cur_r_i);
  assign res_b_o = cur_i ? ctrl_i.survive[n_b] : ctrl_i.birth[n_b];

  always_comb begin
    above_d = above_q;
    mid_d   = mid_q;
    if (ctrl_i.load) begin
      if (ctrl_i.last) begin
        above_d = 1'b0;
        mid_d   = 1'b0;
      end else begin
        above_d = ctrl_i.mid_valid & mid_q;
        mid_d   = cur_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      mid_q   <= 1'b0;
    end else begin
      above_q <= above_d;
      mid_q   <= mid_d;
    end
  end

  assign above_o = above_q;
  assign mid_o   = mid_q;

endmodule

FILE: hdl/llgs_outq.sv
module llgs_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [llgs_pkg::PUSH_W-1:0] push_cnt_i,
  input  llgs_pkg::out_word_t         push0_i,
  input  llgs_pkg::out_word_t         push1_i,
  input  logic                        pop_i,
  output llgs_pkg::out_word_t         head_o,
  output logic [llgs_pkg::CNT_W-1:0]  count_o
);
  import llgs_pkg::*;

  out_word_t              word_q [OUTQ_DEPTH];
  out_word_t              word_d [OUTQ_DEPTH];
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       base;
  logic [CNT_W-1:0]       base_nx;

  assign base    = count_q - CNT_W'(pop_i);
  assign base_nx = base + CNT_W'(1);
  assign count_d = base + CNT_W'(push_cnt_i);

  // shift down on pop, then append new words behind the survivors
  always_comb begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      if (push_cnt_i != '0 && CNT_W'(i) == base) begin
        word_d[i] = push0_i;
      end else if (push_cnt_i == PUSH_W'(2) && CNT_W'(i) == base_nx) begin
        word_d[i] = push1_i;
      end else if (pop_i && i + 1 < OUTQ_DEPTH) begin
        word_d[i] = word_q[(i + 1 < OUTQ_DEPTH) ? i + 1 : i];
      end else begin
        word_d[i] = word_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      word_q[i] <= word_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = word_q[0];
  assign count_o = count_q;

endmodule
